>>> hdl/tpg_pkg.sv
// Shared constants, codes and helpers for the turtle pen grid plotter.
package tpg_pkg;

  localparam int GRID_SIZE = 16;
  localparam int POS_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int CNT_W     = $clog2(GRID_SIZE + 1);
  localparam int LEN_W     = 8;
  localparam int SUM_W     = LEN_W + 2;
  localparam int OUT_POS_W = 4;
  localparam int CAT_W     = (POS_W > OUT_POS_W) ? POS_W : OUT_POS_W;

  typedef enum logic [2:0] {
    OP_PEN_UP    = 3'd0,
    OP_PEN_DOWN  = 3'd1,
    OP_TURN_R    = 3'd2,
    OP_TURN_L    = 3'd3,
    OP_MOVE      = 3'd4,
    OP_READ_CELL = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_ZERO    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    HDG_EAST  = 2'd0,
    HDG_SOUTH = 2'd1,
    HDG_WEST  = 2'd2,
    HDG_NORTH = 2'd3
  } heading_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MARK,
    S_RESULT
  } fsm_t;

  function automatic logic [OUT_POS_W-1:0] to_out_pos(input logic [POS_W-1:0] pos);
    logic [CAT_W-1:0] tmp;
    tmp = CAT_W'(pos);
    return tmp[OUT_POS_W-1:0];
  endfunction

endpackage

>>> hdl/tpg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/turtle_pen_grid_plotter.sv
// Top level of the turtle pen grid plotter: command sequencer around a row-wide grid RAM.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------------
//   in      | request   | in_valid, in_ready, in_opcode, in_move_length,
//           |           | in_query_row, in_query_column
//   out     | result    | out_valid, out_ready, out_status, out_pen_row_now,
//           |           | out_pen_column_now, out_heading_now, out_pen_is_down,
//           |           | out_cell_value
//
// One request is worked at a time. A marking move does the read-modify-write of one grid
// row per cycle: a horizontal move touches a single row, a vertical move of n cells n rows.
// Reset clears per-row valid bits at once, so no clearing pass is needed.
// A result waiting on out_ready holds the sequencer in its result state.
module turtle_pen_grid_plotter
  import tpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_opcode,
  input  logic [LEN_W-1:0]     in_move_length,
  input  logic [3:0]           in_query_row,
  input  logic [3:0]           in_query_column,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [OUT_POS_W-1:0] out_pen_row_now,
  output logic [OUT_POS_W-1:0] out_pen_column_now,
  output logic [1:0]           out_heading_now,
  output logic                 out_pen_is_down,
  output logic                 out_cell_value
);

  fsm_t                 state_r, state_nxt;
  logic [POS_W-1:0]     pen_row_r, pen_row_nxt;
  logic [POS_W-1:0]     pen_col_r, pen_col_nxt;
  logic [1:0]           heading_r, heading_nxt;
  logic                 pen_down_r, pen_down_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 cell_r, cell_nxt;
  logic [POS_W-1:0]     qrow_r, qrow_nxt;
  logic [POS_W-1:0]     qcol_r, qcol_nxt;
  logic                 qhit_r, qhit_nxt;
  logic [POS_W-1:0]     rd_row_r, rd_row_nxt;
  logic [CNT_W-1:0]     rows_left_r, rows_left_nxt;
  logic                 step_up_r, step_up_nxt;
  logic                 wr_pend_r, wr_pend_nxt;
  logic [POS_W-1:0]     wr_row_r, wr_row_nxt;
  logic [GRID_SIZE-1:0] mask_r, mask_nxt;
  logic [GRID_SIZE-1:0] row_valid_r, row_valid_nxt;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [POS_W-1:0]     out_row_r, out_col_r;
  logic [1:0]           out_heading_r;
  logic                 out_pen_r, out_cell_r;

  logic                 ram_we, ram_re;
  logic [POS_W-1:0]     ram_waddr, ram_raddr;
  logic [GRID_SIZE-1:0] ram_wdata, ram_rdata;

  logic [SUM_W-1:0]     len_ext, row_ext, col_ext, grid_ext, one_ext;
  logic [POS_W-1:0]     east_col, west_col, south_row, north_row;
  logic [POS_W-1:0]     lo_col, hi_col;
  logic                 refuse;
  logic [GRID_SIZE-1:0] hmask, vmask;
  logic                 out_free;

  tpg_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign len_ext   = SUM_W'(in_move_length);
  assign row_ext   = SUM_W'(pen_row_r);
  assign col_ext   = SUM_W'(pen_col_r);
  assign grid_ext  = SUM_W'(GRID_SIZE);
  assign one_ext   = SUM_W'(1);
  assign east_col  = POS_W'(col_ext + len_ext - one_ext);
  assign west_col  = POS_W'(col_ext - len_ext + one_ext);
  assign south_row = POS_W'(row_ext + len_ext - one_ext);
  assign north_row = POS_W'(row_ext - len_ext + one_ext);
  assign lo_col    = (heading_r == HDG_WEST) ? west_col : pen_col_r;
  assign hi_col    = (heading_r == HDG_EAST) ? east_col : pen_col_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    case (heading_r)
      HDG_EAST:  refuse = (col_ext + len_ext) > grid_ext;
      HDG_SOUTH: refuse = (row_ext + len_ext) > grid_ext;
      HDG_WEST:  refuse = len_ext > (col_ext + one_ext);
      default:   refuse = len_ext > (row_ext + one_ext);
    endcase
  end

  always_comb begin
    for (int i = 0; i < GRID_SIZE; i++) begin
      hmask[i] = (POS_W'(i) >= lo_col) && (POS_W'(i) <= hi_col);
      vmask[i] = (POS_W'(i) == pen_col_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pen_row_nxt   = pen_row_r;
    pen_col_nxt   = pen_col_r;
    heading_nxt   = heading_r;
    pen_down_nxt  = pen_down_r;
    status_nxt    = status_r;
    cell_nxt      = cell_r;
    qrow_nxt      = qrow_r;
    qcol_nxt      = qcol_r;
    qhit_nxt      = qhit_r;
    rd_row_nxt    = rd_row_r;
    rows_left_nxt = rows_left_r;
    step_up_nxt   = step_up_r;
    wr_pend_nxt   = 1'b0;
    wr_row_nxt    = wr_row_r;
    mask_nxt      = mask_r;
    row_valid_nxt = row_valid_r;
    in_ready      = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rd_row_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_row_r;
    ram_wdata     = (row_valid_r[wr_row_r] ? ram_rdata : '0) | mask_r;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_nxt = ST_DONE;
          cell_nxt   = 1'b0;
          state_nxt  = S_RESULT;
          case (in_opcode)
            OP_PEN_UP:   pen_down_nxt = 1'b0;
            OP_PEN_DOWN: pen_down_nxt = 1'b1;
            OP_TURN_R:   heading_nxt  = heading_r + 2'd1;
            OP_TURN_L:   heading_nxt  = heading_r + 2'd3;
            OP_MOVE: begin
              if (in_move_length == '0) begin
                status_nxt = ST_ZERO;
              end else if (refuse) begin
                status_nxt = ST_REFUSED;
              end else begin
                case (heading_r)
                  HDG_EAST:  pen_col_nxt = east_col;
                  HDG_SOUTH: pen_row_nxt = south_row;
                  HDG_WEST:  pen_col_nxt = west_col;
                  default:   pen_row_nxt = north_row;
                endcase
                rd_row_nxt  = pen_row_r;
                step_up_nxt = (heading_r == HDG_SOUTH);
                if (heading_r == HDG_EAST || heading_r == HDG_WEST) begin
                  rows_left_nxt = CNT_W'(1);
                  mask_nxt      = hmask;
                end else begin
                  rows_left_nxt = CNT_W'(in_move_length);
                  mask_nxt      = vmask;
                end
                if (pen_down_r) begin
                  state_nxt = S_MARK;
                end
              end
            end
            OP_READ_CELL: begin
              qrow_nxt  = POS_W'(in_query_row);
              qcol_nxt  = POS_W'(in_query_column);
              qhit_nxt  = (int'(in_query_row) < GRID_SIZE) &&
                          (int'(in_query_column) < GRID_SIZE);
              ram_re    = 1'b1;
              ram_raddr = POS_W'(in_query_row);
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cell_nxt  = qhit_r && row_valid_r[qrow_r] && ram_rdata[qcol_r];
        state_nxt = S_RESULT;
      end
      S_MARK: begin
        if (rows_left_r != '0) begin
          ram_re        = 1'b1;
          ram_raddr     = rd_row_r;
          wr_pend_nxt   = 1'b1;
          wr_row_nxt    = rd_row_r;
          rows_left_nxt = rows_left_r - CNT_W'(1);
          rd_row_nxt    = step_up_r ? rd_row_r + POS_W'(1) : rd_row_r - POS_W'(1);
        end else begin
          state_nxt = S_RESULT;
        end
        if (wr_pend_r) begin
          ram_we                  = 1'b1;
          row_valid_nxt[wr_row_r] = 1'b1;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pen_row_r   <= '0;
      pen_col_r   <= '0;
      heading_r   <= HDG_EAST;
      pen_down_r  <= 1'b0;
      rows_left_r <= '0;
      wr_pend_r   <= 1'b0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pen_row_r   <= pen_row_nxt;
      pen_col_r   <= pen_col_nxt;
      heading_r   <= heading_nxt;
      pen_down_r  <= pen_down_nxt;
      rows_left_r <= rows_left_nxt;
      wr_pend_r   <= wr_pend_nxt;
      row_valid_r <= row_valid_nxt;
      if (state_r == S_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    cell_r    <= cell_nxt;
    qrow_r    <= qrow_nxt;
    qcol_r    <= qcol_nxt;
    qhit_r    <= qhit_nxt;
    rd_row_r  <= rd_row_nxt;
    step_up_r <= step_up_nxt;
    wr_row_r  <= wr_row_nxt;
    mask_r    <= mask_nxt;
    if (state_r == S_RESULT && out_free) begin
      out_status_r  <= status_r;
      out_row_r     <= pen_row_r;
      out_col_r     <= pen_col_r;
      out_heading_r <= heading_r;
      out_pen_r     <= pen_down_r;
      out_cell_r    <= cell_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_pen_row_now    = to_out_pos(out_row_r);
  assign out_pen_column_now = to_out_pos(out_col_r);
  assign out_heading_now    = out_heading_r;
  assign out_pen_is_down    = out_pen_r;
  assign out_cell_value     = out_cell_r;

`ifndef ASSERT_OFF
  // The last row read of a marking walk always has its write-back pending.
  a_last_write_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK && rows_left_r == '0) |-> wr_pend_r)
    else $error("marking walk ended without a pending row write");

  // Each marking cycle with rows left consumes exactly one row.
  a_rows_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK && rows_left_r != '0) |=>
      (rows_left_r == $past(rows_left_r) - CNT_W'(1)))
    else $error("row counter did not step during marking");

  // An accepted request leaves idle and blocks further requests until its result is released.
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new request accepted while one is in progress");

  // A result released from the sequencer is presented on the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("finished result was not presented");
`endif

endmodule

>>> test/turtle_pen_grid_plotter_check.sv
// Result checker for the turtle pen grid plotter: tracks the pen and grid, compares every result.
module turtle_pen_grid_plotter_check
  import tpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [2:0]           in_opcode,
  input  logic [LEN_W-1:0]     in_move_length,
  input  logic [3:0]           in_query_row,
  input  logic [3:0]           in_query_column,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           out_status,
  input  logic [OUT_POS_W-1:0] out_pen_row_now,
  input  logic [OUT_POS_W-1:0] out_pen_column_now,
  input  logic [1:0]           out_heading_now,
  input  logic                 out_pen_is_down,
  input  logic                 out_cell_value,
  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output int                   drawn_moves,
  output int                   marked_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] column;
    logic [1:0]           heading;
    logic                 pen_down;
    logic                 marked;
  } plot_result_t;

  logic         ink [GRID_SIZE][GRID_SIZE];
  int           pen_r;
  int           pen_c;
  logic [1:0]   hdg;
  logic         pen_dn;
  plot_result_t awaited_results [$];

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    plot_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result arrived with no request outstanding");
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      check_field("status", want.status, out_status);
      check_field("pen_row_now", want.row, out_pen_row_now);
      check_field("pen_column_now", want.column, out_pen_column_now);
      check_field("heading_now", want.heading, out_heading_now);
      check_field("pen_is_down", want.pen_down, out_pen_is_down);
      check_field("cell_value", want.marked, out_cell_value);
      checked++;
    end
  endtask

  task automatic plot_command(input logic [2:0] op, input logic [LEN_W-1:0] len,
                              input logic [3:0] qr, input logic [3:0] qc);
    plot_result_t res;
    int           n;
    int           step_r;
    int           step_c;
    logic         fits;
    res = '0;
    res.status = ST_DONE;
    case (op)
      OP_PEN_UP: pen_dn = 1'b0;
      OP_PEN_DOWN: pen_dn = 1'b1;
      OP_TURN_R: hdg = hdg + 2'd1;
      OP_TURN_L: hdg = hdg + 2'd3;
      OP_MOVE: begin
        n = len;
        step_r = 0;
        step_c = 0;
        case (hdg)
          HDG_EAST: begin
            step_c = 1;
            fits = (pen_c + n <= GRID_SIZE);
          end
          HDG_SOUTH: begin
            step_r = 1;
            fits = (pen_r + n <= GRID_SIZE);
          end
          HDG_WEST: begin
            step_c = -1;
            fits = (n <= pen_c + 1);
          end
          default: begin
            step_r = -1;
            fits = (n <= pen_r + 1);
          end
        endcase
        if (n == 0) begin
          res.status = ST_ZERO;
        end else if (!fits) begin
          res.status = ST_REFUSED;
        end else begin
          if (pen_dn) begin
            for (int i = 0; i < n; i++) ink[pen_r + i * step_r][pen_c + i * step_c] = 1'b1;
            drawn_moves++;
          end
          pen_r += (n - 1) * step_r;
          pen_c += (n - 1) * step_c;
        end
      end
      OP_READ_CELL: begin
        if (qr < GRID_SIZE && qc < GRID_SIZE) res.marked = ink[qr][qc];
        if (res.marked) marked_reads++;
      end
      default: ;
    endcase
    res.row = pen_r[OUT_POS_W-1:0];
    res.column = pen_c[OUT_POS_W-1:0];
    res.heading = hdg;
    res.pen_down = pen_dn;
    awaited_results.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GRID_SIZE; r++)
        for (int c = 0; c < GRID_SIZE; c++) ink[r][c] = 1'b0;
      pen_r = 0;
      pen_c = 0;
      hdg = HDG_EAST;
      pen_dn = 1'b0;
      awaited_results.delete();
      fail_count = 0;
      checked = 0;
      drawn_moves = 0;
      marked_reads = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) plot_command(in_opcode, in_move_length, in_query_row,
                                             in_query_column);
    end
    pending = awaited_results.size();
  end

endmodule

>>> test/turtle_pen_grid_plotter_test.sv
// Top of the turtle pen grid plotter regression: clock, reset, request traffic and verdict.
module turtle_pen_grid_plotter_test;
  import tpg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_opcode = '0;
  logic [LEN_W-1:0]     in_move_length = '0;
  logic [3:0]           in_query_row = '0;
  logic [3:0]           in_query_column = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_status;
  logic [OUT_POS_W-1:0] out_pen_row_now;
  logic [OUT_POS_W-1:0] out_pen_column_now;
  logic [1:0]           out_heading_now;
  logic                 out_pen_is_down;
  logic                 out_cell_value;

  int fail_count;
  int pending;
  int checked;
  int drawn_moves;
  int marked_reads;
  int send_idle_pct = 8;
  int recv_idle_pct = 80;
  int recv_hold_left = 0;
  int requests_sent = 0;

  turtle_pen_grid_plotter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_move_length     (in_move_length),
    .in_query_row       (in_query_row),
    .in_query_column    (in_query_column),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_pen_row_now    (out_pen_row_now),
    .out_pen_column_now (out_pen_column_now),
    .out_heading_now    (out_heading_now),
    .out_pen_is_down    (out_pen_is_down),
    .out_cell_value     (out_cell_value)
  );

  turtle_pen_grid_plotter_check plot_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_move_length     (in_move_length),
    .in_query_row       (in_query_row),
    .in_query_column    (in_query_column),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_pen_row_now    (out_pen_row_now),
    .out_pen_column_now (out_pen_column_now),
    .out_heading_now    (out_heading_now),
    .out_pen_is_down    (out_pen_is_down),
    .out_cell_value     (out_cell_value),
    .fail_count         (fail_count),
    .pending            (pending),
    .checked            (checked),
    .drawn_moves        (drawn_moves),
    .marked_reads       (marked_reads)
  );

  always #5 clk = ~clk;

  initial begin
    forever begin
      @(posedge clk);
      if (recv_hold_left > 0) begin
        out_ready <= 1'b0;
        recv_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [LEN_W-1:0] len,
                              input logic [3:0] qr, input logic [3:0] qc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_move_length <= len;
    in_query_row <= qr;
    in_query_column <= qc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_random_requests(input int count);
    int               pick;
    int               len_pick;
    logic [2:0]       op;
    logic [LEN_W-1:0] len;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) op = OP_PEN_UP;
      else if (pick < 22) op = OP_PEN_DOWN;
      else if (pick < 32) op = OP_TURN_R;
      else if (pick < 42) op = OP_TURN_L;
      else if (pick < 75) op = OP_MOVE;
      else if (pick < 95) op = OP_READ_CELL;
      else if (pick < 97) op = OP_SPARE_6;
      else op = OP_SPARE_7;
      len_pick = $urandom_range(9);
      if (len_pick < 8) len = LEN_W'($urandom_range(GRID_SIZE, 1));
      else if (len_pick == 8) len = '0;
      else len = LEN_W'($urandom_range(255));
      send_request(op, len, 4'($urandom_range(15)), 4'($urandom_range(15)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Draw the border of the grid, probing the refusal limit on every side.
    send_request(OP_READ_CELL, 8'd0, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd0, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd1, 4'd0, 4'd0);
    send_request(OP_PEN_DOWN, 8'd0, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd16, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd1, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd2, 4'd0, 4'd0);
    send_request(OP_READ_CELL, 8'd0, 4'd0, 4'd15);
    send_request(OP_READ_CELL, 8'd0, 4'd15, 4'd15);
    send_request(OP_TURN_R, 8'd0, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd255, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd16, 4'd0, 4'd0);
    send_request(OP_TURN_R, 8'd0, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd16, 4'd0, 4'd0);
    send_request(OP_TURN_R, 8'd0, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd17, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd16, 4'd0, 4'd0);
    send_request(OP_PEN_UP, 8'd0, 4'd0, 4'd0);
    send_request(OP_TURN_L, 8'd0, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd2, 4'd0, 4'd0);
    send_request(OP_MOVE, 8'd1, 4'd0, 4'd0);
    send_request(OP_SPARE_6, 8'd128, 4'd8, 4'd8);
    send_request(OP_SPARE_7, 8'd255, 4'd15, 4'd15);
    send_request(OP_READ_CELL, 8'd0, 4'd15, 4'd0);
    send_request(OP_READ_CELL, 8'd0, 4'd7, 4'd7);

    send_random_requests(300);
    send_idle_pct = 80;
    recv_idle_pct = 8;
    send_random_requests(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_left = 200;
    send_random_requests(300);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);

    $display("Sent %0d requests and checked %0d results under three idle patterns.",
             requests_sent, checked);
    $display("Drew %0d marking moves and read back %0d marked cells.",
             drawn_moves, marked_reads);
    if (fail_count == 0 && pending == 0) begin
      $display("turtle_pen_grid_plotter regression: pass");
    end else begin
      $display("turtle_pen_grid_plotter regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("turtle_pen_grid_plotter regression: fail");
    $finish;
  end

endmodule
